// ===== design/drlt_pkg.sv =====
// ----------------------------------------------------------------------------
// drlt_pkg
// Shared sizes, codes, types and saturating arithmetic for the dense ReLU
// training layer.
// ----------------------------------------------------------------------------
package drlt_pkg;

  localparam int NEURONS   = 16;
  localparam int INPUTS    = 1024;
  localparam int FRAC_BITS = 16;
  localparam int LR_FRAC   = 16;

  // Field widths of the channels.
  localparam int FUNC_W   = 3;
  localparam int ROWF_W   = 6;
  localparam int COLF_W   = 12;
  localparam int VAL_W    = 32;
  localparam int LABEL_W  = 6;
  localparam int KIND_W   = 2;
  localparam int NEURON_W = 6;

  // Storage geometry.
  localparam int ROW_W   = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int COL_W   = (INPUTS > 1) ? $clog2(INPUTS) : 1;
  localparam int WADDR_W = ROW_W + COL_W;
  localparam int WDEPTH  = 1 << WADDR_W;
  localparam int NCNT_W  = $clog2(NEURONS + 1);
  localparam int MCNT_W  = $clog2(INPUTS + 1);
  localparam int ACC_W   = 48;

  // Command queue.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int NC_W       = 7;
  localparam int IC_W       = 13;
  localparam int LR_W       = 17;
  localparam int BS_W       = 16;

  localparam logic [CFG_IDX_W-1:0] REG_NEURON_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_SIZE   = 2'd3;

  // Update step unit.
  localparam int MAG_W    = 48;
  localparam int MAG_HALF = MAG_W / 2;
  localparam int PROD_W   = MAG_HALF + LR_W;
  localparam int PSUM_W   = 66;
  localparam int NUM_W    = PSUM_W - LR_FRAC;
  localparam int DIVCNT_W = $clog2(NUM_W);

  localparam logic [FUNC_W-1:0] FUNC_WRITE_WEIGHT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE_BIAS   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ACTIVATION   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TARGET       = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_HIDDEN_ERROR = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE       = 3'd5;

  localparam logic [KIND_W-1:0] KIND_ACT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GRAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

  localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] ONE_FIX  = 64'sd1 <<< FRAC_BITS;

  typedef enum logic [2:0] {
    OP_WWEIGHT, OP_WBIAS, OP_ACT, OP_TARGET, OP_HIDDEN, OP_UPDATE
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [VAL_W-1:0]  value;
    logic [LABEL_W-1:0]       label;
    logic                     last;
    logic                     store;
  } cmd_t;

  typedef struct packed {
    logic [NCNT_W-1:0] used_n;
    logic [MCNT_W-1:0] used_m;
    logic [LR_W-1:0]   lr;
    logic [BS_W-1:0]   bs;
  } cfg_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE,
    S_FWD_INIT, S_FWD_RUN, S_FWD_BIAS, S_FWD_RND, S_FWD_OUT,
    S_BWD_INIT, S_BWD_RUN, S_BWD_OUT,
    S_UPD_RD, S_UPD_CHK, S_UPD_WAIT, S_UPD_BCHK, S_UPD_BWAIT, S_UPD_OUT
  } back_state_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_SUM, ST_DIV, ST_DONE
  } step_state_t;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add64 = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add64 = s[63:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [63:0] v);
    if (v > 64'sd140737488355327) begin
      sat48 = {1'b0, {(ACC_W-1){1'b1}}};
    end else if (v < -64'sd140737488355328) begin
      sat48 = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      sat48 = v[ACC_W-1:0];
    end
  endfunction

  function automatic logic [MAG_W-1:0] abs48(input logic signed [ACC_W-1:0] v);
    abs48 = v[ACC_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

endpackage

// ===== design/drlt_if.sv =====
// ----------------------------------------------------------------------------
// drlt_in_if / drlt_out_if
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface drlt_in_if;
  import drlt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [ROWF_W-1:0]       row;
  logic [COLF_W-1:0]       col;
  logic signed [VAL_W-1:0] value;
  logic [LABEL_W-1:0]      label;
  logic                    last;

  modport source (output valid, func, row, col, value, label, last, input ready);
  modport sink (input valid, func, row, col, value, label, last, output ready);
endinterface

interface drlt_out_if;
  import drlt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [NEURON_W-1:0]     neuron;
  logic signed [VAL_W-1:0] value_res;
  logic                    last_res;

  modport source (output valid, kind, neuron, value_res, last_res, input ready);
  modport sink (input valid, kind, neuron, value_res, last_res, output ready);
endinterface

// ===== design/drlt_ram.sv =====
// ----------------------------------------------------------------------------
// drlt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module drlt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/drlt_front.sv =====
// ----------------------------------------------------------------------------
// drlt_front
// Accepts input transactions, drops those that have no effect and turns
// the rest into commands for the execution side.
// ----------------------------------------------------------------------------
module drlt_front (
  drlt_in_if.sink          items,
  input  drlt_pkg::cfg_t   cfg,
  input  logic             clearing,
  input  logic             q_full,
  output logic             push,
  output drlt_pkg::cmd_t   cmd
);
  import drlt_pkg::*;

  logic keep;
  logic row_ok;
  logic col_ok;

  assign items.ready = !q_full && !clearing;
  assign row_ok      = int'(items.row) < NEURONS;
  assign col_ok      = int'(items.col) < INPUTS;

  always_comb begin
    keep       = 1'b0;
    cmd.op     = OP_WWEIGHT;
    cmd.row    = items.row[ROW_W-1:0];
    cmd.col    = items.col[COL_W-1:0];
    cmd.value  = items.value;
    cmd.label  = items.label;
    cmd.last   = items.last;
    cmd.store  = col_ok;
    case (items.func)
      FUNC_WRITE_WEIGHT: begin
        cmd.op = OP_WWEIGHT;
        keep   = row_ok && col_ok;
      end
      FUNC_WRITE_BIAS: begin
        cmd.op = OP_WBIAS;
        keep   = row_ok;
      end
      FUNC_ACTIVATION: begin
        cmd.op = OP_ACT;
        keep   = col_ok || items.last;
      end
      FUNC_TARGET: begin
        cmd.op = OP_TARGET;
        keep   = 1'b1;
      end
      FUNC_HIDDEN_ERROR: begin
        // An error for a neuron that is not in use has no effect.
        cmd.op = OP_HIDDEN;
        keep   = int'(items.row) < int'(cfg.used_n);
      end
      FUNC_UPDATE: begin
        cmd.op = OP_UPDATE;
        keep   = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = items.valid && items.ready && keep;
endmodule

// ===== design/drlt_queue.sv =====
// ----------------------------------------------------------------------------
// drlt_queue
// Short command queue between the front and the execution side.
// ----------------------------------------------------------------------------
module drlt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  drlt_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output drlt_pkg::cmd_t head
);
  import drlt_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_pop;

  assign full   = count == (QPTR_W + 1)'(QDEPTH);
  assign avail  = count != '0;
  assign head   = slots[rd_ptr];
  assign do_pop = pop && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end
endmodule

// ===== design/drlt_step.sv =====
// ----------------------------------------------------------------------------
// drlt_step
// Update step magnitude: round(mag * lr / (batch << 16)) by two partial
// products and a restoring divider that retires one quotient bit a cycle.
// ----------------------------------------------------------------------------
module drlt_step (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [drlt_pkg::MAG_W-1:0]   mag,
  input  drlt_pkg::cfg_t               cfg,
  output logic                         done,
  output logic [drlt_pkg::NUM_W-1:0]   q
);
  import drlt_pkg::*;

  step_state_t         state;
  step_state_t         state_next;
  logic [MAG_W-1:0]    mag_r;
  logic [LR_W-1:0]     lr_r;
  logic [BS_W-1:0]     bs_r;
  logic [PROD_W-1:0]   p_hi;
  logic [PROD_W-1:0]   p_lo;
  logic [PSUM_W-1:0]   psum;
  logic [NUM_W-1:0]    num;
  logic [BS_W-1:0]     rem;
  logic [BS_W:0]       trial;
  logic                ge;
  logic [DIVCNT_W-1:0] cnt;
  logic                div_last;

  // Adding half the divisor before the shift gives round half up.
  assign psum  = PSUM_W'({p_hi, {MAG_HALF{1'b0}}}) + PSUM_W'(p_lo)
               + (PSUM_W'(bs_r) << (LR_FRAC - 1));
  assign trial = {rem, num[NUM_W-1]};
  assign ge    = trial >= {1'b0, bs_r};
  assign div_last = cnt == DIVCNT_W'(NUM_W - 1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_MUL;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_DIV;
      ST_DIV:  if (div_last) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    done = 1'b0;
    case (state)
      ST_DONE: done = 1'b1;
      default: done = 1'b0;
    endcase
  end

  assign q = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        mag_r <= mag;
        lr_r  <= cfg.lr;
        bs_r  <= (cfg.bs == '0) ? BS_W'(1) : cfg.bs;
      end
      ST_MUL: begin
        p_hi <= mag_r[MAG_W-1:MAG_HALF] * lr_r;
        p_lo <= mag_r[MAG_HALF-1:0] * lr_r;
      end
      ST_SUM: begin
        num <= psum[LR_FRAC +: NUM_W];
        rem <= '0;
        cnt <= '0;
      end
      ST_DIV: begin
        rem <= ge ? BS_W'(trial - {1'b0, bs_r}) : trial[BS_W-1:0];
        num <= {num[NUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end
endmodule

// ===== design/drlt_back.sv =====
// ----------------------------------------------------------------------------
// drlt_back
// Execution side: owns the weight, accumulator and input memories and runs
// the forward pass, gradient accumulation and the update sweep.
// ----------------------------------------------------------------------------
module drlt_back (
  input  logic           clk,
  input  logic           rst,
  input  drlt_pkg::cfg_t cfg,
  input  logic           cmd_avail,
  input  drlt_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           clearing,
  drlt_out_if.source     results
);
  import drlt_pkg::*;

  localparam logic [WADDR_W-1:0] KLAST = WADDR_W'(WDEPTH - 1);
  localparam logic [ROW_W-1:0]   NLAST = ROW_W'(NEURONS - 1);

  back_state_t state;
  back_state_t state_next;

  logic [WADDR_W-1:0] k;
  logic [ROW_W-1:0]   ci;
  logic [MCNT_W-1:0]  jj;
  logic [COL_W-1:0]   j1;
  logic [COL_W-1:0]   j2;
  logic               v1;
  logic               v2;

  logic signed [63:0]      s;
  logic signed [63:0]      prod;
  logic signed [ACC_W-1:0] accd;
  logic signed [VAL_W-1:0] g;
  logic signed [VAL_W-1:0] wv;
  logic                    upd_neg;
  logic                    hidden;
  logic [LABEL_W-1:0]      label_r;
  logic signed [VAL_W-1:0] err_r;

  logic signed [VAL_W-1:0] bias_r [NEURONS];
  logic signed [ACC_W-1:0] bacc   [NEURONS];
  logic signed [VAL_W-1:0] act_r  [NEURONS];

  logic                    out_valid;
  logic [KIND_W-1:0]       out_kind;
  logic [NEURON_W-1:0]     out_neuron;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_last;
  logic                    out_free;
  logic                    out_load;

  // Memory ports.
  logic               w_we;
  logic [WADDR_W-1:0] w_waddr;
  logic [VAL_W-1:0]   w_wdata;
  logic [WADDR_W-1:0] w_raddr;
  logic [VAL_W-1:0]   w_rdata;
  logic               a_we;
  logic [WADDR_W-1:0] a_waddr;
  logic [ACC_W-1:0]   a_wdata;
  logic [WADDR_W-1:0] a_raddr;
  logic [ACC_W-1:0]   a_rdata;
  logic               x_we;
  logic [COL_W-1:0]   x_waddr;
  logic [VAL_W-1:0]   x_wdata;
  logic [COL_W-1:0]   x_raddr;
  logic [VAL_W-1:0]   x_rdata;

  logic               step_start;
  logic [MAG_W-1:0]   step_mag;
  logic               step_done;
  logic [NUM_W-1:0]   step_q;

  logic                    issue;
  logic                    pipe_empty;
  logic                    last_i;
  logic signed [63:0]      r_sh;
  logic signed [VAL_W-1:0] act_val;
  logic signed [63:0]      factor;
  logic signed [VAL_W-1:0] g_val;
  logic signed [ACC_W-1:0] acc_new;
  logic [ROW_W-1:0]        k_row;
  logic [COL_W-1:0]        k_col;
  logic                    need_step;
  logic                    bias_need;
  logic signed [63:0]      step_s;
  logic signed [VAL_W-1:0] w_upd;
  logic signed [VAL_W-1:0] b_upd;

  drlt_ram #(.WIDTH(VAL_W), .DEPTH(WDEPTH)) u_wram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  drlt_ram #(.WIDTH(ACC_W), .DEPTH(WDEPTH)) u_aram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  drlt_ram #(.WIDTH(VAL_W), .DEPTH(INPUTS)) u_xram (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
    .raddr(x_raddr), .rdata(x_rdata)
  );

  drlt_step u_step (
    .clk(clk), .rst(rst), .start(step_start), .mag(step_mag), .cfg(cfg),
    .done(step_done), .q(step_q)
  );

  assign out_free   = !out_valid || results.ready;
  assign issue      = (state == S_FWD_RUN || state == S_BWD_RUN) && (jj < cfg.used_m);
  assign pipe_empty = !issue && !v1 && !v2;
  assign last_i     = NCNT_W'(ci) == cfg.used_n - 1'b1;
  assign k_row      = k[WADDR_W-1:COL_W];
  assign k_col      = k[COL_W-1:0];

  // Forward result: round-shifted sum, saturated, then ReLU.
  assign r_sh    = s >>> FRAC_BITS;
  assign act_val = (r_sh > 64'sd0) ? sat32(r_sh) : '0;

  always_comb begin
    if (hidden) begin
      factor = 64'(err_r);
    end else if (LABEL_W'(ci) == label_r) begin
      factor = (64'(act_r[ci]) - ONE_FIX) <<< 1;
    end else begin
      factor = 64'(act_r[ci]) <<< 1;
    end
  end
  assign g_val   = (act_r[ci] > 0) ? sat32(factor) : '0;
  assign acc_new = sat48(64'(accd) + (sat_add64(prod, RND_HALF) >>> FRAC_BITS));

  assign need_step = (NCNT_W'(k_row) < cfg.used_n) && (MCNT_W'(k_col) < cfg.used_m)
                   && (a_rdata != '0);
  assign bias_need = (NCNT_W'(ci) < cfg.used_n) && (bacc[ci] != '0);
  assign step_s    = upd_neg ? -$signed(64'(step_q)) : $signed(64'(step_q));
  assign w_upd     = sat32(64'(wv) - step_s);
  assign b_upd     = sat32(64'(bias_r[ci]) - step_s);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (k == KLAST) state_next = S_IDLE;
      S_IDLE: begin
        if (cmd_avail) begin
          case (cmd.op)
            OP_ACT:    if (cmd.last && cfg.used_n != '0) state_next = S_FWD_INIT;
            OP_TARGET: if (cfg.used_n != '0) state_next = S_BWD_INIT;
            OP_HIDDEN: state_next = S_BWD_INIT;
            OP_UPDATE: state_next = S_UPD_RD;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_FWD_INIT: state_next = S_FWD_RUN;
      S_FWD_RUN:  if (pipe_empty) state_next = S_FWD_BIAS;
      S_FWD_BIAS: state_next = S_FWD_RND;
      S_FWD_RND:  state_next = S_FWD_OUT;
      S_FWD_OUT:  if (out_free) state_next = last_i ? S_IDLE : S_FWD_INIT;
      S_BWD_INIT: state_next = S_BWD_RUN;
      S_BWD_RUN:  if (pipe_empty) state_next = S_BWD_OUT;
      S_BWD_OUT:  if (out_free) state_next = (hidden || last_i) ? S_IDLE : S_BWD_INIT;
      S_UPD_RD:   state_next = S_UPD_CHK;
      S_UPD_CHK: begin
        if (need_step) begin
          state_next = S_UPD_WAIT;
        end else begin
          state_next = (k == KLAST) ? S_UPD_BCHK : S_UPD_RD;
        end
      end
      S_UPD_WAIT: if (step_done) state_next = (k == KLAST) ? S_UPD_BCHK : S_UPD_RD;
      S_UPD_BCHK: begin
        if (bias_need) begin
          state_next = S_UPD_BWAIT;
        end else if (ci == NLAST) begin
          state_next = S_UPD_OUT;
        end
      end
      S_UPD_BWAIT: if (step_done) state_next = (ci == NLAST) ? S_UPD_OUT : S_UPD_BCHK;
      S_UPD_OUT:   if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop    = 1'b0;
    clearing   = 1'b0;
    out_load   = 1'b0;
    w_we       = 1'b0;
    w_waddr    = {cmd.row, cmd.col};
    w_wdata    = cmd.value;
    w_raddr    = {ci, jj[COL_W-1:0]};
    a_we       = 1'b0;
    a_waddr    = k;
    a_wdata    = '0;
    a_raddr    = {ci, jj[COL_W-1:0]};
    x_we       = 1'b0;
    x_waddr    = cmd.col;
    x_wdata    = cmd.value;
    x_raddr    = jj[COL_W-1:0];
    step_start = 1'b0;
    step_mag   = abs48(a_rdata);
    case (state)
      S_CLEAR: begin
        clearing = 1'b1;
        a_we     = 1'b1;
      end
      S_IDLE: begin
        cmd_pop = 1'b1;
        w_we    = cmd_avail && cmd.op == OP_WWEIGHT;
        x_we    = cmd_avail && cmd.op == OP_ACT && cmd.store;
      end
      S_FWD_OUT, S_BWD_OUT, S_UPD_OUT: out_load = out_free;
      S_BWD_RUN: begin
        a_we    = v2;
        a_waddr = {ci, j2};
        a_wdata = acc_new;
      end
      S_UPD_RD: begin
        w_raddr = k;
        a_raddr = k;
      end
      S_UPD_CHK: begin
        step_start = need_step;
        a_we       = !need_step;
      end
      S_UPD_WAIT: begin
        a_we    = step_done;
        w_we    = step_done;
        w_waddr = k;
        w_wdata = w_upd;
      end
      S_UPD_BCHK: begin
        step_start = bias_need;
        step_mag   = abs48(bacc[ci]);
      end
      default: begin
      end
    endcase
  end

  // Control state and the reset-cleared bias stores.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      k         <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
      for (int n = 0; n < NEURONS; n++) begin
        bias_r[n] <= '0;
        bacc[n]   <= '0;
      end
    end else begin
      state <= state_next;
      v1    <= issue;
      v2    <= v1;
      if (state == S_CLEAR || (state == S_UPD_CHK && !need_step)
          || (state == S_UPD_WAIT && step_done)) begin
        k <= k + 1'b1;
      end else if (state == S_IDLE) begin
        k <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_IDLE && cmd_avail && cmd.op == OP_WBIAS) begin
        bias_r[cmd.row] <= cmd.value;
      end
      if (state == S_BWD_OUT && out_free) begin
        bacc[ci] <= sat48(64'(bacc[ci]) + 64'(g));
      end
      if (state == S_UPD_BCHK && !bias_need) begin
        bacc[ci] <= '0;
      end
      if (state == S_UPD_BWAIT && step_done) begin
        bias_r[ci] <= b_upd;
        bacc[ci]   <= '0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (issue) begin
      jj <= jj + 1'b1;
      j1 <= jj[COL_W-1:0];
    end
    if (v1) begin
      j2   <= j1;
      accd <= a_rdata;
    end
    case (state)
      S_IDLE: begin
        hidden  <= cmd.op == OP_HIDDEN;
        label_r <= cmd.label;
        err_r   <= cmd.value;
        ci      <= (cmd.op == OP_HIDDEN) ? cmd.row : '0;
      end
      S_FWD_INIT: begin
        s  <= '0;
        jj <= '0;
      end
      S_FWD_RUN: begin
        if (v1) begin
          prod <= $signed(w_rdata) * $signed(x_rdata);
        end
        if (v2) begin
          s <= sat_add64(s, prod);
        end
      end
      S_FWD_BIAS: s <= sat_add64(s, 64'(bias_r[ci]) <<< FRAC_BITS);
      S_FWD_RND:  s <= sat_add64(s, RND_HALF);
      S_FWD_OUT: begin
        if (out_free) begin
          act_r[ci] <= act_val;
          if (!last_i) begin
            ci <= ci + 1'b1;
          end
        end
      end
      S_BWD_INIT: begin
        g  <= g_val;
        jj <= '0;
      end
      S_BWD_RUN: begin
        if (v1) begin
          prod <= $signed(x_rdata) * 64'(g);
        end
      end
      S_BWD_OUT: begin
        if (out_free && !hidden && !last_i) begin
          ci <= ci + 1'b1;
        end
      end
      S_UPD_CHK: begin
        wv      <= w_rdata;
        upd_neg <= a_rdata[ACC_W-1];
      end
      S_UPD_BCHK: begin
        upd_neg <= bacc[ci][ACC_W-1];
        if (!bias_need && ci != NLAST) begin
          ci <= ci + 1'b1;
        end
      end
      S_UPD_BWAIT: begin
        if (step_done && ci != NLAST) begin
          ci <= ci + 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_neuron <= NEURON_W'(ci);
      case (state)
        S_FWD_OUT: begin
          out_kind  <= KIND_ACT;
          out_value <= act_val;
          out_last  <= last_i;
        end
        S_BWD_OUT: begin
          out_kind  <= KIND_GRAD;
          out_value <= g;
          out_last  <= hidden || last_i;
        end
        default: begin
          out_kind   <= KIND_DONE;
          out_neuron <= '0;
          out_value  <= '0;
          out_last   <= 1'b1;
        end
      endcase
    end
  end

  assign results.valid     = out_valid;
  assign results.kind      = out_kind;
  assign results.neuron    = out_neuron;
  assign results.value_res = out_value;
  assign results.last_res  = out_last;
endmodule

// ===== design/dense_relu_layer_train_unit.sv =====
// A forward pass starts after the last element, one MAC a cycle from the
// weight and input memories.
// An update sweeps the whole weight memory; each entry with a nonzero
// gradient waits for the bit-serial divider.
// Reset is synchronous; afterwards the accumulator memory is cleared,
// during which no transaction is accepted.
// ----------------------------------------------------------------------------
// dense_relu_layer_train_unit
// Fully connected ReLU layer with gradient accumulation and SGD update.
// ----------------------------------------------------------------------------
module dense_relu_layer_train_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [drlt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [drlt_pkg::CFG_DATA_W-1:0]   cfg_data,
  drlt_in_if.sink                           items,
  drlt_out_if.source                        results
);
  import drlt_pkg::*;

  logic [NC_W-1:0] neuron_count;
  logic [IC_W-1:0] input_count;
  logic [LR_W-1:0] step_rate;
  logic [BS_W-1:0] batch_size;
  cfg_t            cfg;
  logic            clearing;
  logic            q_full;
  logic            push;
  cmd_t            push_cmd;
  logic            pop;
  logic            avail;
  cmd_t            head;

  always_ff @(posedge clk) begin
    if (rst) begin
      neuron_count <= NC_W'(10);
      input_count  <= IC_W'(784);
      step_rate    <= LR_W'(655);
      batch_size   <= BS_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NEURON_COUNT: neuron_count <= cfg_data[NC_W-1:0];
        REG_INPUT_COUNT:  input_count  <= cfg_data[IC_W-1:0];
        REG_STEP_RATE:    step_rate    <= cfg_data[LR_W-1:0];
        REG_BATCH_SIZE:   batch_size   <= cfg_data[BS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Counts are clamped to the storage that is built.
  assign cfg.used_n = (int'(neuron_count) < NEURONS) ? NCNT_W'(neuron_count)
                                                     : NCNT_W'(NEURONS);
  assign cfg.used_m = (int'(input_count) < INPUTS) ? MCNT_W'(input_count)
                                                   : MCNT_W'(INPUTS);
  assign cfg.lr     = step_rate;
  assign cfg.bs     = batch_size;

  drlt_front u_front (
    .items(items), .cfg(cfg), .clearing(clearing), .q_full(q_full),
    .push(push), .cmd(push_cmd)
  );

  drlt_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_cmd(push_cmd), .full(q_full),
    .pop(pop), .avail(avail), .head(head)
  );

  drlt_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd_avail(avail), .cmd(head),
    .cmd_pop(pop), .clearing(clearing), .results(results)
  );
endmodule

// ===== design/drlt_checker.sv =====
// ----------------------------------------------------------------------------
// drlt_checker
// Port-level checks of the dense ReLU training layer.
// ----------------------------------------------------------------------------
module drlt_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [drlt_pkg::KIND_W-1:0]       out_kind,
  input logic [drlt_pkg::NEURON_W-1:0]     out_neuron,
  input logic [drlt_pkg::VAL_W-1:0]        out_value,
  input logic                              out_last
);
  import drlt_pkg::*;

  // The accumulator clear after reset keeps the input side closed.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready && !out_valid)
    else $error("transaction possible right after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_kind)
      && $stable(out_neuron) && $stable(out_last))
    else $error("stalled result changed");

  a_done_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_DONE |-> out_neuron == '0 && out_value == '0 && out_last)
    else $error("malformed update-done result");

  a_relu_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_ACT |-> !out_value[VAL_W-1])
    else $error("negative activation");
endmodule

bind dense_relu_layer_train_unit drlt_checker u_drlt_checker (
  .clk(clk), .rst(rst), .in_ready(items.ready),
  .out_valid(results.valid), .out_ready(results.ready), .out_kind(results.kind),
  .out_neuron(results.neuron), .out_value(results.value_res),
  .out_last(results.last_res)
);

// ===== sim/drlt_layer_checker.sv =====
// ----------------------------------------------------------------------------
// drlt_layer_checker
// Watches the item, result and register ports of the dense ReLU training
// layer, predicts every result in step with the accepted items and compares
// the results field by field in arrival order.
// ----------------------------------------------------------------------------
module drlt_layer_checker
  import drlt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  drlt_in_if                    items,
  drlt_out_if                   results,
  output int                    fails,
  output int                    waiting,
  output int                    seen
);

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [NEURON_W-1:0] neuron;
    logic [VAL_W-1:0]    value;
    logic                last;
  } layer_out_t;

  layer_out_t expected_outputs[$];

  int     w_mem[NEURONS*INPUTS];
  int     b_mem[NEURONS];
  longint w_grad[NEURONS*INPUTS];
  longint b_grad[NEURONS];
  int     act_mem[NEURONS];
  int     in_mem[INPUTS];

  logic [NC_W-1:0] n_count;
  logic [IC_W-1:0] m_count;
  logic [LR_W-1:0] rate;
  logic [BS_W-1:0] batch;

  function automatic longint add_sat64(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip48(longint v);
    if (v > 64'sd140737488355327) return 64'sd140737488355327;
    if (v < -64'sd140737488355328) return -64'sd140737488355328;
    return v;
  endfunction

  // Shift right by the fraction bits, rounding half up.
  function automatic longint round_frac(longint v);
    return add_sat64(v, 64'sd1 <<< (FRAC_BITS - 1)) >>> FRAC_BITS;
  endfunction

  function automatic int step_param(int w, longint acc, longint unsigned div);
    longint unsigned mag;
    longint unsigned q;
    longint          step;
    mag  = acc[63] ? longint'(-acc) : acc;
    q    = (mag * longint'(rate) + div / 2) / div;
    step = acc[63] ? -longint'(q) : longint'(q);
    return int'(clip32(longint'(w) - step));
  endfunction

  function automatic int used_n();
    return (n_count < NEURONS) ? int'(n_count) : NEURONS;
  endfunction

  function automatic int used_m();
    return (m_count < INPUTS) ? int'(m_count) : INPUTS;
  endfunction

  task automatic push_out(logic [KIND_W-1:0] k, int n, int v, logic l);
    layer_out_t o;
    o.kind   = k;
    o.neuron = n[NEURON_W-1:0];
    o.value  = v;
    o.last   = l;
    expected_outputs.push_back(o);
  endtask

  // ReLU derivative times the error factor, accumulated into the gradients.
  task automatic grad_neuron(int i, longint factor, output int g);
    int     m;
    longint p;
    m = used_m();
    g = (act_mem[i] > 0) ? int'(clip32(factor)) : 0;
    for (int j = 0; j < m; j++) begin
      p = longint'(in_mem[j]) * longint'(g);
      w_grad[i*INPUTS+j] = clip48(w_grad[i*INPUTS+j] + round_frac(p));
    end
    b_grad[i] = clip48(b_grad[i] + longint'(g));
  endtask

  task automatic clear_grads();
    foreach (w_grad[k]) w_grad[k] = 0;
    foreach (b_grad[k]) b_grad[k] = 0;
  endtask

  task automatic model_layer_item(logic [FUNC_W-1:0] f, logic [ROWF_W-1:0] r,
                                  logic [COLF_W-1:0] c, logic [VAL_W-1:0] v,
                                  logic [LABEL_W-1:0] lb, logic l);
    int              n;
    int              m;
    int              g;
    longint          s;
    longint          t;
    longint unsigned div;
    n = used_n();
    m = used_m();
    case (f)
      FUNC_WRITE_WEIGHT: begin
        if (r < NEURONS && c < INPUTS) w_mem[r*INPUTS+c] = v;
      end
      FUNC_WRITE_BIAS: begin
        if (r < NEURONS) b_mem[r] = v;
      end
      FUNC_ACTIVATION: begin
        if (c < INPUTS) in_mem[c] = v;
        if (l) begin
          for (int i = 0; i < n; i++) begin
            s = 0;
            for (int j = 0; j < m; j++) begin
              s = add_sat64(s, longint'(w_mem[i*INPUTS+j]) * longint'(in_mem[j]));
            end
            s = add_sat64(s, longint'(b_mem[i]) <<< FRAC_BITS);
            s = round_frac(s);
            act_mem[i] = (s > 0) ? int'(clip32(s)) : 0;
            push_out(KIND_ACT, i, act_mem[i], i + 1 == n);
          end
        end
      end
      FUNC_TARGET: begin
        for (int i = 0; i < n; i++) begin
          t = (i == lb) ? (64'sd1 <<< FRAC_BITS) : 0;
          grad_neuron(i, 2 * (longint'(act_mem[i]) - t), g);
          push_out(KIND_GRAD, i, g, i + 1 == n);
        end
      end
      FUNC_HIDDEN_ERROR: begin
        if (r < n) begin
          grad_neuron(r, longint'(signed'(v)), g);
          push_out(KIND_GRAD, r, g, 1'b1);
        end
      end
      FUNC_UPDATE: begin
        div = longint'((batch != 0) ? batch : 16'd1) << LR_FRAC;
        for (int i = 0; i < n; i++) begin
          for (int j = 0; j < m; j++) begin
            w_mem[i*INPUTS+j] = step_param(w_mem[i*INPUTS+j], w_grad[i*INPUTS+j], div);
          end
          b_mem[i] = step_param(b_mem[i], b_grad[i], div);
        end
        clear_grads();
        push_out(KIND_DONE, 0, 0, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  task automatic note_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    fails++;
    if (fails <= 10) begin
      $display("MISMATCH %s: expected %h, got %h", what, exp_v, got_v);
    end
  endtask

  task automatic check_result();
    layer_out_t e;
    seen++;
    if (expected_outputs.size() == 0) begin
      fails++;
      if (fails <= 10) begin
        $display("MISMATCH unexpected result kind %0d neuron %0d value %h",
                 results.kind, results.neuron, results.value_res);
      end
    end else begin
      e = expected_outputs.pop_front();
      if (results.kind !== e.kind) note_mismatch("kind", e.kind, results.kind);
      if (results.neuron !== e.neuron) note_mismatch("neuron", e.neuron, results.neuron);
      if (results.value_res !== e.value) note_mismatch("value", e.value, results.value_res);
      if (results.last_res !== e.last) note_mismatch("last", e.last, results.last_res);
    end
  endtask

  initial begin
    fails   = 0;
    waiting = 0;
    seen    = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      n_count = 7'd10;
      m_count = 13'd784;
      rate    = 17'd655;
      batch   = 16'd1;
      foreach (w_mem[k]) w_mem[k] = 0;
      foreach (b_mem[k]) b_mem[k] = 0;
      foreach (act_mem[k]) act_mem[k] = 0;
      foreach (in_mem[k]) in_mem[k] = 0;
      clear_grads();
      expected_outputs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NEURON_COUNT: n_count = cfg_data[NC_W-1:0];
          REG_INPUT_COUNT:  m_count = cfg_data[IC_W-1:0];
          REG_STEP_RATE:    rate    = cfg_data[LR_W-1:0];
          REG_BATCH_SIZE:   batch   = cfg_data[BS_W-1:0];
          default: begin
          end
        endcase
      end
      if (results.valid && results.ready) check_result();
      if (items.valid && items.ready) begin
        model_layer_item(items.func, items.row, items.col, items.value, items.label,
                         items.last);
      end
    end
    waiting = expected_outputs.size();
  end

endmodule

// ===== sim/dense_relu_layer_train_unit_tb.sv =====
// ----------------------------------------------------------------------------
// dense_relu_layer_train_unit_tb
// Drives the training layer through several register settings with directed
// and random weight, bias, activation, gradient and update transactions, with
// random stalls on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module dense_relu_layer_train_unit_tb;
  import drlt_pkg::*;

  localparam int IDLE_LIMIT = 300000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  drlt_in_if  items_if ();
  drlt_out_if results_if ();

  int fails;
  int waiting;
  int seen;
  int items_sent = 0;
  int settings   = 0;
  int idle_count = 0;
  bit fast_tx    = 1'b0;
  bit fast_rx    = 1'b0;
  bit hold_req   = 1'b0;
  bit weight_set[NEURONS*INPUTS];

  dense_relu_layer_train_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items_if),
    .results   (results_if)
  );

  drlt_layer_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items_if),
    .results   (results_if),
    .fails     (fails),
    .waiting   (waiting),
    .seen      (seen)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
    end
    if (idle_count >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random gaps, plus one long hold-off so the block backs up.
  initial begin
    int gap;
    results_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = fast_rx ? 0 : $urandom_range(0, 5);
      if (hold_req) begin
        hold_req = 1'b0;
        gap = 400;
      end
      if (gap > 0) begin
        results_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      results_if.ready <= 1'b1;
      do @(posedge clk); while (!results_if.valid);
      @(negedge clk);
    end
  end

  function automatic logic [31:0] rand_val();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return $urandom_range(0, 32'h80000) - 32'h40000;
    endcase
  endfunction

  task automatic send(logic [FUNC_W-1:0] f, logic [ROWF_W-1:0] r, logic [COLF_W-1:0] c,
                      logic [VAL_W-1:0] v, logic [LABEL_W-1:0] lb, logic l);
    int gap;
    gap = fast_tx ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    items_if.valid <= 1'b1;
    items_if.func  <= f;
    items_if.row   <= r;
    items_if.col   <= c;
    items_if.value <= v;
    items_if.label <= lb;
    items_if.last  <= l;
    do @(posedge clk); while (!items_if.ready);
    @(negedge clk);
    if (f == FUNC_WRITE_WEIGHT && r < NEURONS && c < INPUTS) weight_set[r*INPUTS+c] = 1'b1;
    items_sent++;
  endtask

  task automatic wait_idle();
    items_if.valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic set_regs(int nc, int ic, int lr, int bs);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_NEURON_COUNT;
    cfg_data  <= nc;
    @(negedge clk);
    cfg_index <= REG_INPUT_COUNT;
    cfg_data  <= ic;
    @(negedge clk);
    cfg_index <= REG_STEP_RATE;
    cfg_data  <= lr;
    @(negedge clk);
    cfg_index <= REG_BATCH_SIZE;
    cfg_data  <= bs;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  // Full activation stream; an empty input set still needs the last element.
  task automatic stream(int um);
    if (um == 0) begin
      send(FUNC_ACTIVATION, 0, $urandom_range(0, 4095), rand_val(), 0, 1'b1);
    end else begin
      for (int j = 0; j < um; j++) begin
        send(FUNC_ACTIVATION, 0, j, rand_val(), 0, j == um - 1);
      end
    end
  endtask

  task automatic run_phase(int nc, int ic, int lr, int bs, int n_items, bit pressure);
    int un;
    int um;
    int sent;
    int pick;
    set_regs(nc, ic, lr, bs);
    un = (nc < NEURONS) ? nc : NEURONS;
    um = (ic < INPUTS) ? ic : INPUTS;
    // Every weight the forward pass or update reads must hold a written value.
    for (int i = 0; i < un; i++) begin
      for (int j = 0; j < um; j++) begin
        if (!weight_set[i*INPUTS+j]) send(FUNC_WRITE_WEIGHT, i, j, rand_val(), 0, 1'b0);
      end
    end
    if (pressure) hold_req = 1'b1;
    stream(um);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 19) == 0) fast_tx = !fast_tx;
      if ($urandom_range(0, 19) == 0) fast_rx = !fast_rx;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        stream(um);
        sent += (um == 0) ? 1 : um;
      end else if (pick < 45) begin
        send(FUNC_TARGET, $urandom_range(0, 63), $urandom_range(0, 4095), $urandom(),
             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15),
             $urandom_range(0, 1));
        sent++;
      end else if (pick < 62) begin
        send(FUNC_HIDDEN_ERROR,
             ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15),
             $urandom_range(0, 4095), rand_val(), $urandom_range(0, 63), $urandom_range(0, 1));
        sent++;
      end else if (pick < 66) begin
        send(FUNC_UPDATE, $urandom_range(0, 63), $urandom_range(0, 4095), $urandom(),
             $urandom_range(0, 63), $urandom_range(0, 1));
        sent++;
      end else if (pick < 76) begin
        send(FUNC_WRITE_WEIGHT, $urandom_range(0, 15),
             ($urandom_range(0, 1) == 0) ? $urandom_range(0, (um > 0) ? um - 1 : 0)
                                         : $urandom_range(0, 4095),
             rand_val(), $urandom_range(0, 63), $urandom_range(0, 1));
        sent++;
      end else if (pick < 84) begin
        send(FUNC_WRITE_BIAS, $urandom_range(0, 63), $urandom_range(0, 4095), rand_val(),
             $urandom_range(0, 63), $urandom_range(0, 1));
        sent++;
      end else begin
        // Noise: unknown codes, ignored weight writes and stray elements.
        case ($urandom_range(0, 2))
          0: send(($urandom_range(0, 1) == 0) ? 3'd6 : 3'd7, $urandom_range(0, 63),
                  $urandom_range(0, 4095), $urandom(), $urandom_range(0, 63),
                  $urandom_range(0, 1));
          1: send(FUNC_WRITE_WEIGHT, $urandom_range(16, 63), $urandom_range(0, 4095),
                  $urandom(), $urandom_range(0, 63), $urandom_range(0, 1));
          default: send(FUNC_ACTIVATION, $urandom_range(0, 63), $urandom_range(0, 4095),
                        rand_val(), $urandom_range(0, 63), $urandom_range(0, 1));
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    items_if.valid   = 1'b0;
    items_if.func    = '0;
    items_if.row     = '0;
    items_if.col     = '0;
    items_if.value   = '0;
    items_if.label   = '0;
    items_if.last    = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part on a small layer.
    run_phase(4, 3, 655, 1, 0, 1'b0);
    send(FUNC_WRITE_WEIGHT, 0, 0, 32'h7fffffff, 0, 1'b0);
    send(FUNC_WRITE_WEIGHT, 1, 0, 32'h80000000, 0, 1'b0);
    send(FUNC_WRITE_BIAS, 2, 0, 32'h7fffffff, 0, 1'b0);
    send(FUNC_WRITE_BIAS, 3, 0, 32'h80000000, 0, 1'b0);
    send(FUNC_ACTIVATION, 0, 0, 32'h7fffffff, 0, 1'b0);
    send(FUNC_ACTIVATION, 0, 1, 32'h80000000, 0, 1'b0);
    send(FUNC_ACTIVATION, 0, 2, 32'h00010000, 0, 1'b1);
    send(FUNC_TARGET, 0, 0, 0, 1, 1'b0);
    send(FUNC_TARGET, 0, 0, 0, 63, 1'b0);
    send(FUNC_HIDDEN_ERROR, 0, 0, 32'h7fffffff, 0, 1'b0);
    send(FUNC_HIDDEN_ERROR, 40, 0, 32'h00020000, 0, 1'b0);
    send(FUNC_HIDDEN_ERROR, 3, 0, 32'h80000000, 0, 1'b0);
    send(FUNC_UPDATE, 0, 0, 0, 0, 1'b0);
    send(3'd6, 63, 4095, 32'hffffffff, 63, 1'b1);
    send(3'd7, 0, 0, 0, 0, 1'b0);
    send(FUNC_WRITE_WEIGHT, 20, 5, 32'h12345678, 0, 1'b0);
    send(FUNC_WRITE_WEIGHT, 1, 3000, 32'h12345678, 0, 1'b0);
    send(FUNC_ACTIVATION, 0, 4000, 32'h00030000, 0, 1'b1);
    send(FUNC_WRITE_BIAS, 50, 0, 32'h00010000, 0, 1'b0);
    send(FUNC_TARGET, 0, 0, 0, 2, 1'b0);
    send(FUNC_UPDATE, 0, 0, 0, 0, 1'b0);
    send(FUNC_ACTIVATION, 0, 2, 32'hfffe0000, 0, 1'b1);

    // Register extremes, then random small settings.
    run_phase(1, 1, 0, 0, 40, 1'b0);
    run_phase(64, 2, 65536, 65535, 50, 1'b1);
    run_phase(0, 3, 655, 1, 15, 1'b0);
    run_phase(5, 0, 40000, 3, 30, 1'b0);
    run_phase(3, 8, 655, 2, 20, 1'b0);
    for (int p = 0; p < 5; p++) begin
      run_phase($urandom_range(1, 20), $urandom_range(1, 6), $urandom_range(0, 65536),
                ($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(1, 8), 30, 1'b0);
    end

    wait_idle();
    $display("Covered %0d input transactions over %0d register settings;", items_sent,
             settings);
    $display("%0d results were checked, %0d mismatches counted.", seen, fails);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
